### rtl/core/svsm_pkg.sv
// Shared types and constants for the servo sweep mode controller.
// Holds register map codes, reset values and the sequencer state type.
// No dependencies.
package svsm_pkg;

  localparam int unsigned POT_W  = 10;
  localparam int unsigned WID_W  = 16;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned DB_W   = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned BIT_W  = 4;

  // register index codes (byte address = 4 * index)
  localparam logic [2:0] REG_WIDTH_MIN  = 3'd0;
  localparam logic [2:0] REG_WIDTH_MAX  = 3'd1;
  localparam logic [2:0] REG_TICKS      = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd3;
  localparam logic [2:0] REG_SLOPE      = 3'd4;
  localparam logic [2:0] REG_OFFSET     = 3'd5;
  localparam logic [2:0] REG_GAIN       = 3'd6;

  localparam logic [WID_W-1:0]  RST_WIDTH_MIN = 16'd2400;
  localparam logic [WID_W-1:0]  RST_WIDTH_MAX = 16'd5800;
  localparam logic [TICK_W-1:0] RST_TICKS     = 8'd5;
  localparam logic [DB_W-1:0]   RST_DEBOUNCE  = 12'd1000;
  localparam logic [WID_W-1:0]  RST_SLOPE     = 16'd4004;
  localparam logic [WID_W-1:0]  RST_OFFSET    = 16'd1800;
  localparam logic [WID_W-1:0]  RST_GAIN      = 16'd819;

  localparam logic [BIT_W-1:0] MUL1_LAST = BIT_W'(POT_W - 1);
  localparam logic [BIT_W-1:0] MUL2_LAST = BIT_W'(WID_W - 1);

  localparam logic in_op_poll_c = 1'b0;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POLL  = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_TICK  = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

### rtl/core/servo_sweep_mode_controller.sv
// Servo sweep mode controller: debounce, pot scaling, tick prescale, width update.
// Uses svsm_pkg for register codes, reset values and the state type.
//
// Usage:
//   Input stream (in_*): one beat per item. in_tuser is the kind, 0 poll, 1 timer
//   tick. A poll carries the raw button level and a 10-bit pot sample in in_tdata.
//   Output stream (out_*): exactly one beat per input beat, in order. out_tdata is
//   the pulse width written on an update tick (0 otherwise); out_tuser holds the
//   update flag and the current mode.
//   Config (cfg_*): APB-style, pready tied high, seven registers at 4*index.
//   Write only while the block is idle.
// Sequencing:
//   A poll runs two bit-serial shift-and-add multiplies (10 then 16 steps through
//   one 16-bit adder); its result is loaded into the output register and the
//   next beat can be taken in the cycle after that. A tick goes through the tick
//   and done states; an update tick adds the clamp state (sum, then clamp).
//   One item is in flight at a time; a new beat is taken while the last result
//   still waits in the output register. If the receiver stalls, the block holds
//   the finished result in its done state until the output register frees.
// Reset: registers return to their reset values, width 2400, follow mode.
module servo_sweep_mode_controller
  import svsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] button_level, [10:1] pot_sample, rest zero
  input  logic [0:0]  in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] duty_out
  output logic [1:0]  out_tuser,  // [0] updated, [1] sweep_mode
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // config registers
  logic [WID_W-1:0]  width_min_r, width_max_r, slope_r, offset_r, gain_r;
  logic [TICK_W-1:0] ticks_r;
  logic [DB_W-1:0]   debounce_r;

  // block state
  state_t             state_r;
  logic [WID_W-1:0]   pulse_width_r, target_width_r, sweep_step_r;
  logic [TICK_W-1:0]  tick_count_r;
  logic               sweep_up_r, mode_r, held_r;
  logic signed [CNT_W-1:0] db_count_r;

  // item and datapath
  logic               op_r, button_r;
  logic [POT_W-1:0]   pot_r;
  logic [WID_W-1:0]   hi_r, lo_r;
  logic [BIT_W-1:0]   bit_r;
  logic signed [SUM_W-1:0] w_r;
  logic [WID_W-1:0]   res_duty_r;
  logic               res_upd_r;

  // output register
  logic               out_valid_r;
  logic [WID_W-1:0]   out_duty_r;
  logic               out_upd_r, out_mode_r;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               in_fire;
  logic               out_free;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = {out_mode_r, out_upd_r};

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH_MIN: cfg_prdata = {16'd0, width_min_r};
      REG_WIDTH_MAX: cfg_prdata = {16'd0, width_max_r};
      REG_TICKS:     cfg_prdata = {24'd0, ticks_r};
      REG_DEBOUNCE:  cfg_prdata = {20'd0, debounce_r};
      REG_SLOPE:     cfg_prdata = {16'd0, slope_r};
      REG_OFFSET:    cfg_prdata = {16'd0, offset_r};
      REG_GAIN:      cfg_prdata = {16'd0, gain_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_min_r <= RST_WIDTH_MIN;
      width_max_r <= RST_WIDTH_MAX;
      ticks_r     <= RST_TICKS;
      debounce_r  <= RST_DEBOUNCE;
      slope_r     <= RST_SLOPE;
      offset_r    <= RST_OFFSET;
      gain_r      <= RST_GAIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH_MIN: width_min_r <= cfg_pwdata[WID_W-1:0];
        REG_WIDTH_MAX: width_max_r <= cfg_pwdata[WID_W-1:0];
        REG_TICKS:     ticks_r     <= cfg_pwdata[TICK_W-1:0];
        REG_DEBOUNCE:  debounce_r  <= cfg_pwdata[DB_W-1:0];
        REG_SLOPE:     slope_r     <= cfg_pwdata[WID_W-1:0];
        REG_OFFSET:    offset_r    <= cfg_pwdata[WID_W-1:0];
        REG_GAIN:      gain_r      <= cfg_pwdata[WID_W-1:0];
        default: ;
      endcase
    end
  end

  // serial multiply step: add multiplicand when the low multiplier bit is set,
  // then shift {carry, hi, lo} right by one
  logic [WID_W-1:0] mcand;
  logic [WID_W:0]   mul_sum;
  logic             mul_last;

  assign mcand    = (state_r == S_MUL1) ? slope_r : gain_r;
  assign mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand} : {(WID_W+1){1'b0}});
  assign mul_last = (state_r == S_MUL1) ? (bit_r == MUL1_LAST) : (bit_r == MUL2_LAST);

  // target width = product >> 10 plus offset, saturated to 16 bits
  logic [WID_W:0]   tgt_sum;
  logic [WID_W-1:0] tgt_sat;
  assign tgt_sum = {1'b0, hi_r} + {1'b0, offset_r};
  assign tgt_sat = tgt_sum[WID_W] ? {WID_W{1'b1}} : tgt_sum[WID_W-1:0];

  // prescaler and sweep sum
  logic [TICK_W:0]         tick_next;
  logic                    tick_hit;
  logic signed [SUM_W-1:0] pw_ext, step_ext, tgt_ext;
  assign tick_next = {1'b0, tick_count_r} + {{TICK_W{1'b0}}, 1'b1};
  assign tick_hit  = (tick_next >= {1'b0, ticks_r});
  assign pw_ext    = signed'({2'b00, pulse_width_r});
  assign step_ext  = signed'({2'b00, sweep_step_r});
  assign tgt_ext   = signed'({2'b00, target_width_r});

  // clamp against max first, then min; crossed limits end at min, sweeping up
  logic signed [SUM_W-1:0] max_ext, min_ext, w_hi, w_fin;
  logic                    over_max, under_min;
  assign max_ext   = signed'({2'b00, width_max_r});
  assign min_ext   = signed'({2'b00, width_min_r});
  assign over_max  = (w_r > max_ext);
  assign w_hi      = over_max ? max_ext : w_r;
  assign under_min = (w_hi < min_ext);
  assign w_fin     = under_min ? min_ext : w_hi;

  // debounce compare against the old count
  logic signed [CNT_W-1:0] limit_ext;
  assign limit_ext = signed'({1'b0, debounce_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      pulse_width_r  <= RST_WIDTH_MIN;
      tick_count_r   <= '0;
      sweep_up_r     <= 1'b1;
      mode_r         <= 1'b0;
      held_r         <= 1'b0;
      db_count_r     <= '0;
      target_width_r <= '0;
      sweep_step_r   <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r     <= in_tuser[0];
            button_r <= in_tdata[0];
            pot_r    <= in_tdata[POT_W:1];
            state_r  <= (in_tuser[0] == in_op_poll_c) ? S_POLL : S_TICK;
          end
        end
        S_POLL: begin
          if (!held_r && !button_r) begin
            if (db_count_r == limit_ext) begin
              held_r <= 1'b1;
              mode_r <= !mode_r;
            end else begin
              db_count_r <= db_count_r + 13'sd1;
            end
          end
          if (held_r && button_r) begin
            db_count_r <= db_count_r - 13'sd1;
            if (db_count_r == 13'sd0) begin
              held_r <= 1'b0;
            end
          end
          hi_r    <= '0;
          lo_r    <= {{(WID_W-POT_W){1'b0}}, pot_r};
          bit_r   <= '0;
          state_r <= S_MUL1;
        end
        S_MUL1, S_MUL2: begin
          hi_r  <= mul_sum[WID_W:1];
          lo_r  <= {mul_sum[0], lo_r[WID_W-1:1]};
          bit_r <= bit_r + 1'b1;
          if (mul_last) begin
            if (state_r == S_MUL1) begin
              state_r <= S_ADD;
            end else begin
              sweep_step_r <= mul_sum[WID_W:1];
              res_duty_r   <= '0;
              res_upd_r    <= 1'b0;
              state_r      <= S_DONE;
            end
          end
        end
        S_ADD: begin
          target_width_r <= tgt_sat;
          hi_r           <= '0;
          lo_r           <= tgt_sat;
          bit_r          <= '0;
          state_r        <= S_MUL2;
        end
        S_TICK: begin
          if (tick_hit) begin
            tick_count_r <= '0;
            if (mode_r) begin
              w_r <= sweep_up_r ? (pw_ext + step_ext) : (pw_ext - step_ext);
            end else begin
              w_r <= tgt_ext;
            end
            state_r <= S_CLAMP;
          end else begin
            tick_count_r <= tick_next[TICK_W-1:0];
            res_duty_r   <= '0;
            res_upd_r    <= 1'b0;
            state_r      <= S_DONE;
          end
        end
        S_CLAMP: begin
          if (under_min) begin
            sweep_up_r <= 1'b1;
          end else if (over_max) begin
            sweep_up_r <= 1'b0;
          end
          pulse_width_r <= w_fin[WID_W-1:0];
          res_duty_r    <= w_fin[WID_W-1:0];
          res_upd_r     <= 1'b1;
          state_r       <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_duty_r  <= res_duty_r;
            out_upd_r   <= res_upd_r && op_r;
            out_mode_r  <= mode_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for servo_sweep_mode_controller: a directed table, then random
// phases of polls and timer ticks checked beat by beat against a pulse width predictor.
// Depends on svsm_pkg and the controller RTL.
module tb;
  import svsm_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 230;
  localparam int N_PHASES    = 8;
  localparam int SQUEEZE_LEN = 400;
  localparam int N_ROWS      = 32;

  localparam logic OP_POLL = in_op_poll_c;
  localparam logic OP_TICK = ~in_op_poll_c;

  typedef struct packed {
    logic [15:0] duty;
    logic        updated;
    logic        sweep;
  } pulse_t;

  // fixed = 1 means the expected beat is typed into the row, not predicted
  typedef struct packed {
    logic   fixed;
    pulse_t want;
  } note_t;

  typedef struct packed {
    logic        is_reg;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic        op;
    logic        level;
    logic [9:0]  pot;
    logic        fixed;
    pulse_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [0] button_level, [10:1] pot_sample, rest zero
  logic [0:0]  in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] duty_out
  logic [1:0]  out_tuser;  // [0] updated, [1] sweep_mode
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  servo_sweep_mode_controller dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers and state
  logic [15:0]        lim_lo, lim_hi, slope_q10, pot_offset, gain_q16;
  logic [7:0]         ticks_per_upd;
  logic [11:0]        press_limit;
  logic [16:0]        pulse_w;
  logic [7:0]         tick_cnt;
  logic               going_up, sweeping, press_held;
  logic signed [12:0] bounce_cnt;
  logic [15:0]        target_w, sweep_step;

  pulse_t expected_pulses [$];
  note_t  row_notes [$];
  int     errors = 0;
  int     beats_in = 0;
  int     beats_out = 0;
  int     quiet = 0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  bit     squeeze_req = 1'b0;

  function automatic pulse_t servo_advance(logic op, logic level, logic [9:0] pot);
    pulse_t             r;
    logic signed [12:0] prev;
    int unsigned        t;
    int                 nxt;
    int                 w;
    r = '0;
    if (op == OP_POLL) begin
      if (!press_held && level == 1'b0) begin
        if (bounce_cnt == $signed({1'b0, press_limit})) begin
          press_held = 1'b1;
          sweeping = ~sweeping;
        end else begin
          bounce_cnt = bounce_cnt + 13'sd1;
        end
      end
      if (press_held && level == 1'b1) begin
        prev = bounce_cnt;
        bounce_cnt = bounce_cnt - 13'sd1;
        if (prev == 13'sd0) press_held = 1'b0;
      end
      t = ((32'(pot) * 32'(slope_q10)) >> 10) + 32'(pot_offset);
      if (t > 32'hFFFF) t = 32'hFFFF;
      target_w = 16'(t);
      sweep_step = 16'((32'(target_w) * 32'(gain_q16)) >> 16);
    end else begin
      nxt = int'(tick_cnt) + 1;
      if (nxt >= int'(ticks_per_upd)) begin
        tick_cnt = '0;
        if (sweeping) begin
          // signed sum, so a step past zero lands on the lower clamp
          w = going_up ? int'(pulse_w) + int'(sweep_step) : int'(pulse_w) - int'(sweep_step);
        end else begin
          w = int'(target_w);
        end
        if (w > int'(lim_hi)) begin
          w = int'(lim_hi);
          going_up = 1'b0;
        end
        if (w < int'(lim_lo)) begin
          w = int'(lim_lo);
          going_up = 1'b1;
        end
        pulse_w = 17'(w);
        r.duty = pulse_w[15:0];
        r.updated = 1'b1;
      end else begin
        tick_cnt = 8'(nxt);
      end
    end
    r.sweep = sweeping;
    return r;
  endfunction

  function automatic row_t poll_row(logic level, logic [9:0] pot);
    row_t r;
    r = '0;
    r.op = OP_POLL;
    r.level = level;
    r.pot = pot;
    return r;
  endfunction

  function automatic row_t tick_row();
    row_t r;
    r = '0;
    r.op = OP_TICK;
    return r;
  endfunction

  function automatic row_t reg_row(logic [2:0] idx, logic [15:0] val);
    row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t expect_row(row_t r, logic [15:0] duty, logic upd, logic mode);
    r.fixed = 1'b1;
    r.want.duty = duty;
    r.want.updated = upd;
    r.want.sweep = mode;
    return r;
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic flag_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // setup then access; psel stays up so back-to-back writes need no release
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WIDTH_MIN: lim_lo = val;
      REG_WIDTH_MAX: lim_hi = val;
      REG_TICKS:     ticks_per_upd = val[7:0];
      REG_DEBOUNCE:  press_limit = val[11:0];
      REG_SLOPE:     slope_q10 = val;
      REG_OFFSET:    pot_offset = val;
      REG_GAIN:      gain_q16 = val;
      default: ;
    endcase
  endtask

  task automatic send_item(input logic op, input logic level, input logic [9:0] pot,
                           input note_t note);
    row_notes.push_back(note);
    beats_in++;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    in_tdata <= {5'd0, pot, level};
    in_tuser <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_tx(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // every item yields one beat, so matching counts means the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (beats_out != beats_in) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(input int p);
    logic [15:0] v [0:6];
    drain();
    case (p)
      0: v = '{16'd2400, 16'd5800, 16'd3, 16'd3, 16'd4004, 16'd1800, 16'd819};
      1: v = '{16'h0000, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'h0000, 16'hFFFF};
      6: v = '{16'hFFFF, 16'h0000, 16'd255, 16'd4095, 16'h0000, 16'hFFFF, 16'h0000};
      // count left high by the previous phase now sits above the limit
      7: v = '{16'd2400, 16'd5800, 16'd0, 16'd2, 16'd4004, 16'd1800, 16'd3276};
      default: begin
        v[REG_WIDTH_MIN] = 16'($urandom_range(0, 8000));
        v[REG_WIDTH_MAX] = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                           16'(v[REG_WIDTH_MIN] + $urandom_range(0, 8000));
        v[REG_TICKS]     = 16'($urandom_range(0, 6));
        v[REG_DEBOUNCE]  = 16'($urandom_range(0, 8));
        v[REG_SLOPE]     = (p == 5) ? 16'($urandom) : 16'($urandom_range(0, 16000));
        v[REG_OFFSET]    = (p == 5) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        v[REG_GAIN]      = (p == 5) ? 16'($urandom) : 16'($urandom_range(0, 30000));
      end
    endcase
    for (int i = REG_WIDTH_MIN; i <= REG_GAIN; i++) write_reg(3'(i), v[i]);
    tx_steady = (p == 0 || p == 3);
    rx_steady = (p == 3);
  endtask

  always @(posedge clk) begin : scoreboard
    pulse_t predicted;
    pulse_t want;
    pulse_t got;
    note_t  note;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = servo_advance(in_tuser[0], in_tdata[0], in_tdata[10:1]);
      note = row_notes.pop_front();
      expected_pulses.push_back(note.fixed ? note.want : predicted);
    end
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      got = {out_tdata, out_tuser[0], out_tuser[1]};
      if (expected_pulses.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, duty %0d", $time, out_tdata);
      end else begin
        want = expected_pulses.pop_front();
        if (got.duty !== want.duty) flag_field("duty_out", want.duty, got.duty);
        if (got.updated !== want.updated) flag_field("updated", want.updated, got.updated);
        if (got.sweep !== want.sweep) flag_field("sweep_mode", want.sweep, got.sweep);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("servo_sweep_mode_controller: mismatch");
      $finish;
    end
  end

  initial begin : receiver
    int   r;
    int   len;
    logic rdy;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        // long hold-off so the block backs up and stalls its input
        squeeze_req = 1'b0;
        out_tready <= 1'b0;
        repeat (SQUEEZE_LEN - 1) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (rx_steady || r < 55) begin
          rdy = 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 92) begin
          rdy = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          len = $urandom_range(10, 60);
        end
        out_tready <= rdy;
        repeat (len - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    row_t       rows [0:N_ROWS-1];
    logic       op;
    logic       level;
    logic [9:0] pot;
    logic       btn;
    int         btn_run;
    int         run_cap;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    lim_lo = RST_WIDTH_MIN;
    lim_hi = RST_WIDTH_MAX;
    ticks_per_upd = RST_TICKS;
    press_limit = RST_DEBOUNCE;
    slope_q10 = RST_SLOPE;
    pot_offset = RST_OFFSET;
    gain_q16 = RST_GAIN;
    pulse_w = 17'(RST_WIDTH_MIN);
    tick_cnt = '0;
    going_up = 1'b1;
    sweeping = 1'b0;
    press_held = 1'b0;
    bounce_cnt = '0;
    target_w = '0;
    sweep_step = '0;
    btn = 1'b1;
    btn_run = 0;

    rows = '{
      expect_row(tick_row(), 16'd0, 1'b0, 1'b0),
      expect_row(poll_row(1'b1, 10'd0), 16'd0, 1'b0, 1'b0),
      reg_row(REG_TICKS, 16'd0),                        // every tick updates
      expect_row(tick_row(), 16'd2400, 1'b1, 1'b0),     // target below lower clamp
      reg_row(REG_DEBOUNCE, 16'd0),
      expect_row(poll_row(1'b0, 10'h3FF), 16'd0, 1'b0, 1'b1),
      tick_row(),
      poll_row(1'b1, 10'h3FF),
      poll_row(1'b0, 10'd512),
      expect_row(poll_row(1'b0, 10'd512), 16'd0, 1'b0, 1'b0),
      reg_row(REG_SLOPE, 16'hFFFF),
      reg_row(REG_OFFSET, 16'hFFFF),
      poll_row(1'b1, 10'h3FF),                          // target saturates
      reg_row(REG_GAIN, 16'hFFFF),
      poll_row(1'b1, 10'h3FF),
      expect_row(tick_row(), 16'd5800, 1'b1, 1'b0),
      reg_row(REG_WIDTH_MIN, 16'hFFFF),
      reg_row(REG_WIDTH_MAX, 16'h0000),
      expect_row(tick_row(), 16'hFFFF, 1'b1, 1'b0),     // crossed limits
      reg_row(REG_WIDTH_MIN, 16'h0000),
      reg_row(REG_WIDTH_MAX, 16'hFFFF),
      poll_row(1'b0, 10'd0),
      expect_row(poll_row(1'b0, 10'd0), 16'd0, 1'b0, 1'b1),
      tick_row(),
      tick_row(),
      expect_row(tick_row(), 16'd0, 1'b1, 1'b1),        // sweep goes below zero
      poll_row(1'b1, 10'h3FF),
      reg_row(REG_DEBOUNCE, 16'd5),
      poll_row(1'b0, 10'h2AA),
      poll_row(1'b0, 10'h155),
      reg_row(REG_DEBOUNCE, 16'd0),
      poll_row(1'b0, 10'd0)                             // count already past limit
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (rows[i].is_reg) begin
        if (i > 0 && !rows[i-1].is_reg) drain();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].op, rows[i].level, rows[i].pot, note_t'{rows[i].fixed, rows[i].want});
        pause_tx(tx_gap());
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      start_phase(p);
      run_cap = (press_limit > 10) ? 15 : int'(press_limit) + 5;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 40) squeeze_req = 1'b1;
        op = $urandom_range(0, 1) ? OP_TICK : OP_POLL;
        // button held in runs so presses and releases get past the debounce
        if (btn_run == 0) begin
          btn = ~btn;
          btn_run = $urandom_range(1, run_cap);
        end
        if (op == OP_POLL) btn_run--;
        level = ($urandom_range(0, 11) == 0) ? 1'($urandom_range(0, 1)) : btn;
        if ($urandom_range(0, 9) == 0) begin
          pot = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        end else begin
          pot = 10'($urandom);
        end
        send_item(op, level, pot, '0);
        pause_tx(tx_gap());
      end
    end

    in_tvalid <= 1'b0;
    while (beats_out != beats_in) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_pulses.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, expected_pulses.size());
    end
    if (errors == 0) begin
      $display("servo_sweep_mode_controller: match");
    end else begin
      $display("servo_sweep_mode_controller: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/svsm_pkg.sv
rtl/core/servo_sweep_mode_controller.sv
bench/tb.sv
